// ===== design/u8d_pkg.sv =====
// shared types and constants of the utf-8 stream decoder
`timescale 1ns / 1ps

package u8d_pkg;

  // width of the running byte offset; the reported offset is its low 32 bits
  localparam int unsigned OFFSET_WIDTH = 32;

  localparam int unsigned CP_WIDTH     = 21;
  localparam int unsigned REPORT_WIDTH = 32;

  typedef enum logic [0:0] {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CODE_POINT  = 2'd0,
    ST_END         = 2'd1,
    ST_ENC_INVALID = 2'd2,
    ST_OP_INVALID  = 2'd3
  } status_t;

  localparam logic [7:0] CONT_PAYLOAD_MASK = 8'h3f;

endpackage

// ===== design/u8d_in_if.sv =====
// input channel: one byte or end marker per word
`timescale 1ns / 1ps

interface u8d_in_if;
  import u8d_pkg::*;

  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] byte_value;

  modport source (output valid, output op, output byte_value, input ready);
  modport sink   (input valid, input op, input byte_value, output ready);
endinterface

// ===== design/u8d_out_if.sv =====
// output channel: one decode result per word
`timescale 1ns / 1ps

interface u8d_out_if;
  import u8d_pkg::*;

  logic                             valid;
  logic                             ready;
  status_t                          status;
  logic [CP_WIDTH-1:0]              code_point;
  logic [REPORT_WIDTH-1:0]          byte_offset;

  modport source (output valid, output status, output code_point, output byte_offset,
                  input ready);
  modport sink   (input valid, input status, input code_point, input byte_offset,
                  output ready);
endinterface

// ===== design/utf8_stream_decoder.sv =====
// utf-8 stream decoder: one byte per word in, one code point or status word out
//
// din carries one word per byte (op data) or an end marker (op end).
// dout carries a status, a code point and the byte offset past the last
// complete code point. a lead or middle byte of a multi-byte sequence
// produces no output word; its last byte produces the code point.
// a result word is registered and appears on dout in the cycle after its input
// word is accepted. throughput: one input word per cycle while dout is not stalled,
// set by the single decode step between the decoder state and the output register.
// the output register frees up in the same cycle dout is taken, so din stays
// ready while dout.ready is high; if dout stalls with a word waiting, din
// drops ready until that word is taken.
// after an encoding error or an end marker every further word reports
// operation invalid until reset.
// rst (synchronous) clears the decoder state and drops dout.valid; there is
// no warm-up after reset.
`timescale 1ns / 1ps

module utf8_stream_decoder (
  input  logic clk,
  input  logic rst,
  u8d_in_if.sink    din,
  u8d_out_if.source dout
);
  import u8d_pkg::*;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_HAVE  = 2'd1,
    PH_ENDED = 2'd2,
    PH_ERROR = 2'd3
  } phase_t;

  logic [CP_WIDTH-1:0]     accumulator, accumulator_next;
  logic [1:0]              bytes_pending, bytes_pending_next;
  logic [OFFSET_WIDTH-1:0] byte_count, byte_count_next;
  phase_t                  phase, phase_next;
  logic [2:0]              seq_len, seq_len_next;

  logic                    out_valid;
  status_t                 out_status;
  logic [CP_WIDTH-1:0]     out_code_point;
  logic [REPORT_WIDTH-1:0] out_byte_offset;

  logic                    emit_next;
  status_t                 status_next;
  logic [CP_WIDTH-1:0]     code_point_next;
  logic [CP_WIDTH-1:0]     acc_shifted;
  logic                    accept;
  logic [7:0]              b;

  assign din.ready        = !out_valid || dout.ready;
  assign accept           = din.valid && din.ready;
  assign dout.valid       = out_valid;
  assign dout.status      = out_status;
  assign dout.code_point  = out_code_point;
  assign dout.byte_offset = out_byte_offset;

  assign b           = din.byte_value;
  assign acc_shifted = {accumulator[CP_WIDTH-7:0], b[5:0] & CONT_PAYLOAD_MASK[5:0]};

  always_comb begin
    accumulator_next   = accumulator;
    bytes_pending_next = bytes_pending;
    byte_count_next    = byte_count;
    phase_next         = phase;
    seq_len_next       = seq_len;
    emit_next          = 1'b0;
    status_next        = ST_ENC_INVALID;
    code_point_next    = '0;

    if (phase == PH_ENDED || phase == PH_ERROR) begin
      emit_next   = 1'b1;
      status_next = ST_OP_INVALID;
    end else if (din.op == OP_END) begin
      emit_next = 1'b1;
      if (bytes_pending != 2'd0) begin
        // end in the middle of a sequence
        phase_next         = PH_ERROR;
        bytes_pending_next = 2'd0;
        seq_len_next       = 3'd0;
        status_next        = ST_ENC_INVALID;
      end else begin
        phase_next  = PH_ENDED;
        status_next = ST_END;
      end
    end else if (bytes_pending == 2'd0) begin
      if (!b[7]) begin
        accumulator_next = CP_WIDTH'(b);
        byte_count_next  = byte_count + OFFSET_WIDTH'(1);
        phase_next       = PH_HAVE;
        emit_next        = 1'b1;
        status_next      = ST_CODE_POINT;
        code_point_next  = CP_WIDTH'(b);
      end else if (!b[6] || (b[5] && b[4] && b[3])) begin
        // stray continuation byte or lead byte f8-ff
        phase_next         = PH_ERROR;
        bytes_pending_next = 2'd0;
        seq_len_next       = 3'd0;
        emit_next          = 1'b1;
        status_next        = ST_ENC_INVALID;
      end else if (!b[5]) begin
        accumulator_next   = CP_WIDTH'(b[4:0]);
        bytes_pending_next = 2'd1;
        seq_len_next       = 3'd2;
      end else if (!b[4]) begin
        accumulator_next   = CP_WIDTH'(b[3:0]);
        bytes_pending_next = 2'd2;
        seq_len_next       = 3'd3;
      end else begin
        accumulator_next   = CP_WIDTH'(b[2:0]);
        bytes_pending_next = 2'd3;
        seq_len_next       = 3'd4;
      end
    end else if (b[7:6] != 2'b10) begin
      phase_next         = PH_ERROR;
      bytes_pending_next = 2'd0;
      seq_len_next       = 3'd0;
      emit_next          = 1'b1;
      status_next        = ST_ENC_INVALID;
    end else begin
      accumulator_next   = acc_shifted;
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        byte_count_next = byte_count + OFFSET_WIDTH'(seq_len);
        seq_len_next    = 3'd0;
        phase_next      = PH_HAVE;
        emit_next       = 1'b1;
        status_next     = ST_CODE_POINT;
        code_point_next = acc_shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      bytes_pending <= 2'd0;
      byte_count    <= '0;
      phase         <= PH_START;
      seq_len       <= 3'd0;
      out_valid     <= 1'b0;
    end else if (accept) begin
      accumulator     <= accumulator_next;
      bytes_pending   <= bytes_pending_next;
      byte_count      <= byte_count_next;
      phase           <= phase_next;
      seq_len         <= seq_len_next;
      out_valid       <= emit_next;
      out_status      <= status_next;
      out_code_point  <= code_point_next;
      out_byte_offset <= REPORT_WIDTH'(byte_count_next);
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // code point field is zero on every non code point word
  a_cp_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_CODE_POINT) |-> out_code_point == '0)
    else $error("code point not zero on status word");

  // once ended or failed, every accepted word reports operation invalid
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && (phase == PH_ENDED || phase == PH_ERROR))
      |=> (out_valid && out_status == ST_OP_INVALID))
    else $error("word after end or error not reported as invalid operation");

  // a pending sequence only exists while the stream is active
  a_pending_active: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != 2'd0) |-> (phase == PH_START || phase == PH_HAVE))
    else $error("bytes pending in a closed stream");

  // pending count and sequence length agree
  a_seq_len: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != 2'd0) |-> (seq_len > 3'(bytes_pending)))
    else $error("sequence length inconsistent with pending count");

  // the offset moves only with a code point word
  a_offset_moves: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && byte_count != $past(byte_count))
      |-> (out_valid && out_status == ST_CODE_POINT))
    else $error("byte offset changed without a code point");
`endif

endmodule
